### hdl/tialu_pkg.sv
// ----------------------------------------------------------------------------
// tialu_pkg
// Shared types, operation codes and helpers for the typed integer ALU.
// ----------------------------------------------------------------------------
package tialu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    FN_ADD  = 5'd0,
    FN_SUB  = 5'd1,
    FN_MUL  = 5'd2,
    FN_DIV  = 5'd3,
    FN_MOD  = 5'd4,
    FN_AND  = 5'd5,
    FN_OR   = 5'd6,
    FN_XOR  = 5'd7,
    FN_SHL  = 5'd8,
    FN_SHR  = 5'd9,
    FN_LAND = 5'd10,
    FN_LOR  = 5'd11,
    FN_GE   = 5'd12,
    FN_GT   = 5'd13,
    FN_LE   = 5'd14,
    FN_LT   = 5'd15,
    FN_EQ   = 5'd16,
    FN_NE   = 5'd17
  } func_t;

  // Width select codes
  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } wsel_t;

  localparam int unsigned DW = 64;  // datapath width

  // Registered input item
  typedef struct packed {
    logic [4:0]    func;
    wsel_t         wsel;
    logic          sgn;
    logic [DW-1:0] lhs;
    logic [DW-1:0] rhs;
  } item_t;

  // Per-stage payload of the pipeline
  typedef struct packed {
    logic          is_div;   // div or mod in flight
    logic          is_mod;
    logic          is_mul;
    wsel_t         wsel;
    logic          err;
    logic [DW-1:0] res;      // simple result, or low partial product
    logic [31:0]   px;       // cross partial products (upper half)
    logic [DW-1:0] rem;      // partial remainder
    logic [DW-1:0] quo;      // dividend shifting out, quotient shifting in
    logic [DW-1:0] mb;       // divisor magnitude
    logic          na;
    logic          nb;
  } stage_t;

  function automatic logic [DW-1:0] wmask(wsel_t ws);
    logic [DW-1:0] m;
    unique case (ws)
      W8:      m = 64'h0000_0000_0000_00FF;
      W16:     m = 64'h0000_0000_0000_FFFF;
      W32:     m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // One restoring divide step: one quotient bit
  function automatic stage_t div_step(stage_t s);
    stage_t        o;
    logic [DW:0]   t;
    logic [DW:0]   d;
    o = s;
    t = {s.rem, s.quo[DW-1]};
    d = t - {1'b0, s.mb};
    if (!d[DW]) begin
      o.rem = d[DW-1:0];
      o.quo = {s.quo[DW-2:0], 1'b1};
    end else begin
      o.rem = t[DW-1:0];
      o.quo = {s.quo[DW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hdl/tialu_if.sv
// ----------------------------------------------------------------------------
// tialu_in_if / tialu_out_if
// Valid/ready channels for ALU items and results.
// ----------------------------------------------------------------------------
interface tialu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [1:0]  width_sel;
  logic        is_signed;
  logic [63:0] lhs;
  logic [63:0] rhs;

  modport source (output valid, func, width_sel, is_signed, lhs, rhs, input ready);
  modport sink   (input valid, func, width_sel, is_signed, lhs, rhs, output ready);
endinterface

interface tialu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        error;

  modport source (output valid, result, error, input ready);
  modport sink   (input valid, result, error, output ready);
endinterface

### hdl/tialu_prep.sv
// ----------------------------------------------------------------------------
// tialu_prep
// Operand decode: extension, simple operations, multiplier partial products
// and divider setup. Pure combinational stage body.
// ----------------------------------------------------------------------------
module tialu_prep (
  input  tialu_pkg::item_t  item,
  output tialu_pkg::stage_t st
);

  logic [63:0] m, a, b, ma, mb, s_amt, minv, shl_r, shr_r;
  logic        na, nb, lt_ab, lt_ba, a_nz, b_nz, big_shift;
  logic [6:0]  wbits;

  // Extend operands to 64 bits
  always_comb begin
    m     = tialu_pkg::wmask(item.wsel);
    wbits = 7'd8 << item.wsel;
    a     = item.lhs & m;
    b     = item.rhs & m;
    if (item.sgn && (a & (m ^ (m >> 1))) != 64'd0) a = a | ~m;
    if (item.sgn && (b & (m ^ (m >> 1))) != 64'd0) b = b | ~m;
    na    = item.sgn & a[63];
    nb    = item.sgn & b[63];
    ma    = na ? (64'd0 - a) : a;
    mb    = nb ? (64'd0 - b) : b;
    minv  = m ^ (m >> 1);
  end

  // Shifts and compares
  always_comb begin
    s_amt     = item.rhs & m;
    big_shift = (s_amt >= {57'd0, wbits});
    shl_r     = big_shift ? 64'd0 : (a << s_amt[5:0]);
    if (big_shift) shr_r = na ? '1 : 64'd0;
    else           shr_r = item.sgn ? 64'($signed(a) >>> s_amt[5:0]) : (a >> s_amt[5:0]);
    lt_ab     = ({a[63] ^ item.sgn, a[62:0]} < {b[63] ^ item.sgn, b[62:0]});
    lt_ba     = ({b[63] ^ item.sgn, b[62:0]} < {a[63] ^ item.sgn, a[62:0]});
    a_nz      = (a & m) != 64'd0;
    b_nz      = (b & m) != 64'd0;
  end

  // Stage payload
  always_comb begin
    st        = '0;
    st.wsel   = item.wsel;
    st.rem    = 64'd0;
    st.quo    = ma;
    st.mb     = mb;
    st.na     = na;
    st.nb     = nb;
    st.px     = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
    unique case (item.func)
      tialu_pkg::FN_ADD:  st.res = a + b;
      tialu_pkg::FN_SUB:  st.res = a - b;
      tialu_pkg::FN_MUL:  begin
        st.res    = 64'(a[31:0]) * 64'(b[31:0]);
        st.is_mul = 1'b1;
      end
      tialu_pkg::FN_DIV, tialu_pkg::FN_MOD: begin
        st.is_div = 1'b1;
        st.is_mod = (item.func == tialu_pkg::FN_MOD);
        st.err    = (mb == 64'd0) || (item.sgn && (a & m) == minv && (b & m) == m);
      end
      tialu_pkg::FN_AND:  st.res = a & b;
      tialu_pkg::FN_OR:   st.res = a | b;
      tialu_pkg::FN_XOR:  st.res = a ^ b;
      tialu_pkg::FN_SHL:  st.res = shl_r;
      tialu_pkg::FN_SHR:  st.res = shr_r;
      tialu_pkg::FN_LAND: st.res = {63'd0, a_nz & b_nz};
      tialu_pkg::FN_LOR:  st.res = {63'd0, a_nz | b_nz};
      tialu_pkg::FN_GE:   st.res = {63'd0, !lt_ab};
      tialu_pkg::FN_GT:   st.res = {63'd0, lt_ba};
      tialu_pkg::FN_LE:   st.res = {63'd0, !lt_ba};
      tialu_pkg::FN_LT:   st.res = {63'd0, lt_ab};
      tialu_pkg::FN_EQ:   st.res = {63'd0, a == b};
      tialu_pkg::FN_NE:   st.res = {63'd0, a != b};
      default:            st.res = 64'd0;
    endcase
  end

endmodule

### hdl/typed_integer_alu.sv
// ----------------------------------------------------------------------------
// typed_integer_alu
// Pipelined typed integer ALU: 8/16/32/64-bit, signed or unsigned operands.
//
//   channel | dir | payload
//   in_ch   | in  | func, width_sel, is_signed, lhs, rhs
//   out_ch  | out | result, error
//
// One item enters per cycle while the skid slot is free; every operation runs
// through the 64-step restoring divider (one quotient bit per stage).
// Reset (rst_n, synchronous) clears all stage valid bits and the skid slot.
// A one-entry skid register after the last stage takes the final result when
// the output stalls, so the pipe still advances; the whole pipe then holds
// until the skid entry is transferred.
// ----------------------------------------------------------------------------
module typed_integer_alu (
  input  logic  clk,
  input  logic  rst_n,
  tialu_in_if.sink    in_ch,
  tialu_out_if.source out_ch
);

  localparam int unsigned NSTEP = 64;

  logic                adv;
  tialu_pkg::item_t    item_r;
  logic                item_v_r;
  tialu_pkg::stage_t   prep_st;
  tialu_pkg::stage_t   stg_r [NSTEP+1];
  logic [NSTEP:0]      stg_v_r;
  logic [63:0]         fin_res_r, fin_res_nxt, skid_res_r;
  logic                fin_err_r, fin_v_r, skid_err_r, skid_v_r;

  // Pipe moves whenever the skid slot is free
  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) item_v_r <= 1'b0;
    else if (adv) item_v_r <= in_ch.valid;
    if (adv && in_ch.valid) begin
      item_r.func <= in_ch.func;
      item_r.wsel <= tialu_pkg::wsel_t'(in_ch.width_sel);
      item_r.sgn  <= in_ch.is_signed;
      item_r.lhs  <= in_ch.lhs;
      item_r.rhs  <= in_ch.rhs;
    end
  end

  tialu_prep u_prep (.item(item_r), .st(prep_st));

  // Prep register
  always_ff @(posedge clk) begin
    if (!rst_n) stg_v_r[0] <= 1'b0;
    else if (adv) stg_v_r[0] <= item_v_r;
    if (adv) stg_r[0] <= prep_st;
  end

  // Divider steps; first step also sums the multiplier partial products
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    tialu_pkg::stage_t step_nxt;
    always_comb begin
      step_nxt = tialu_pkg::div_step(stg_r[i]);
      if (i == 0 && stg_r[i].is_mul)
        step_nxt.res = stg_r[i].res + {stg_r[i].px, 32'd0};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) stg_v_r[i+1] <= 1'b0;
      else if (adv) stg_v_r[i+1] <= stg_v_r[i];
      if (adv) stg_r[i+1] <= step_nxt;
    end
  end

  // Final sign fix and width mask
  always_comb begin
    tialu_pkg::stage_t s;
    s = stg_r[NSTEP];
    if (!s.is_div)             fin_res_nxt = s.res;
    else if (s.mb == 64'd0)    fin_res_nxt = 64'd0;
    else if (s.is_mod)         fin_res_nxt = s.na ? (64'd0 - s.rem) : s.rem;
    else                       fin_res_nxt = (s.na != s.nb) ? (64'd0 - s.quo) : s.quo;
    fin_res_nxt = fin_res_nxt & tialu_pkg::wmask(s.wsel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (adv) fin_v_r <= stg_v_r[NSTEP];
    if (adv) begin
      fin_res_r <= fin_res_nxt;
      fin_err_r <= stg_r[NSTEP].err;
    end
  end

  // Skid slot catches the last stage when the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) skid_v_r <= 1'b0;
    else if (skid_v_r) skid_v_r <= !out_ch.ready;
    else skid_v_r <= fin_v_r && !out_ch.ready;
    if (!skid_v_r) begin
      skid_res_r <= fin_res_r;
      skid_err_r <= fin_err_r;
    end
  end

  assign out_ch.valid  = skid_v_r || fin_v_r;
  assign out_ch.result = skid_v_r ? skid_res_r : fin_res_r;
  assign out_ch.error  = skid_v_r ? skid_err_r : fin_err_r;

  // Checks
  a_skid_shows: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_ch.valid && out_ch.result == skid_res_r)
    else $error("skid entry not presented");
  a_skid_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_ch.ready)
    else $error("input taken while skid full");
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && $stable(skid_res_r))
    else $error("stalled result lost");
  a_err_divonly: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r[NSTEP] && stg_r[NSTEP].err |-> stg_r[NSTEP].is_div)
    else $error("error flag on non-divide op");

endmodule

### bench/typed_integer_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_integer_alu_checker
// Watches the item and result channels of the typed integer ALU, computes
// the expected result of every accepted item and compares it, in order,
// with the results the block returns.
// ----------------------------------------------------------------------------
module typed_integer_alu_checker (
  input  logic       clk,
  input  logic       rst_n,
  tialu_in_if.sink   in_mon,
  tialu_out_if.sink  out_mon,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [63:0] result;
    logic        error;
  } alu_answer_t;

  alu_answer_t answer_q[$];
  int          mismatch_count;

  assign fail_count = mismatch_count;

  // Widen a width-bit pattern, sign extended when requested
  function automatic logic [63:0] widen(logic [63:0] v, logic [63:0] m, int unsigned w,
                                        logic sgn);
    logic [63:0] x;
    x = v & m;
    if (sgn && w < 64 && x[w-1]) x = x | ~m;
    return x;
  endfunction

  function automatic logic below(logic [63:0] a, logic [63:0] b, logic sgn);
    if (sgn) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // Expected answer of one item
  function automatic alu_answer_t alu_answer(logic [4:0] fn, logic [1:0] ws, logic sgn,
                                             logic [63:0] lhs, logic [63:0] rhs);
    alu_answer_t ans;
    int unsigned w;
    logic [63:0] m, a, b, r, ma, mb, q, s;
    logic        na, nb, err;
    w   = 8 << ws;
    m   = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    a   = widen(lhs, m, w, sgn);
    b   = widen(rhs, m, w, sgn);
    r   = '0;
    err = 1'b0;
    case (fn)
      tialu_pkg::FN_ADD: r = a + b;
      tialu_pkg::FN_SUB: r = a - b;
      tialu_pkg::FN_MUL: r = a * b;
      tialu_pkg::FN_DIV, tialu_pkg::FN_MOD: begin
        na = sgn && a[63];
        nb = sgn && b[63];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        if (mb == 0) begin
          err = 1'b1;
        end else begin
          if (sgn && (a & m) == (64'd1 << (w - 1)) && (b & m) == m) err = 1'b1;
          if (fn == tialu_pkg::FN_DIV) begin
            q = ma / mb;
            r = (na != nb) ? -q : q;
          end else begin
            q = ma % mb;
            r = na ? -q : q;
          end
        end
      end
      tialu_pkg::FN_AND: r = a & b;
      tialu_pkg::FN_OR:  r = a | b;
      tialu_pkg::FN_XOR: r = a ^ b;
      tialu_pkg::FN_SHL: begin
        s = b & m;
        r = (s >= w) ? '0 : (a << s);
      end
      tialu_pkg::FN_SHR: begin
        s  = b & m;
        na = sgn && a[63];
        if (s >= w) r = na ? '1 : '0;
        else if (na) r = $signed(a) >>> s;
        else r = a >> s;
      end
      tialu_pkg::FN_LAND: r = {63'd0, ((a & m) != 0 && (b & m) != 0)};
      tialu_pkg::FN_LOR:  r = {63'd0, ((a & m) != 0 || (b & m) != 0)};
      tialu_pkg::FN_GE:   r = {63'd0, !below(a, b, sgn)};
      tialu_pkg::FN_GT:   r = {63'd0, below(b, a, sgn)};
      tialu_pkg::FN_LE:   r = {63'd0, !below(b, a, sgn)};
      tialu_pkg::FN_LT:   r = {63'd0, below(a, b, sgn)};
      tialu_pkg::FN_EQ:   r = {63'd0, ((a & m) == (b & m))};
      tialu_pkg::FN_NE:   r = {63'd0, ((a & m) != (b & m))};
      default: r = '0;
    endcase
    ans.result = r & m;
    ans.error  = err;
    return ans;
  endfunction

  // Record each item transfer, check each result transfer
  always @(posedge clk) begin
    alu_answer_t exp_ans;
    if (!rst_n) begin
      answer_q.delete();
      mismatch_count <= 0;
      pending_count  <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        answer_q.push_back(alu_answer(in_mon.func, in_mon.width_sel, in_mon.is_signed,
                                      in_mon.lhs, in_mon.rhs));
      if (out_mon.valid && out_mon.ready) begin
        if (answer_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result transfer: result=%h error=%b",
                     out_mon.result, out_mon.error);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_ans = answer_q.pop_front();
          if (exp_ans.result !== out_mon.result || exp_ans.error !== out_mon.error) begin
            if (mismatch_count < 10)
              $display("mismatch: expected result=%h error=%b, got result=%h error=%b",
                       exp_ans.result, exp_ans.error, out_mon.result, out_mon.error);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_count <= answer_q.size();
    end
  end

endmodule

### bench/typed_integer_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_integer_alu_tb
// Drives directed corner items and then random items into the typed integer
// ALU with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module typed_integer_alu_tb;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  int   stall_left;
  bit   stall_enable;

  tialu_in_if  in_ch();
  tialu_out_if out_ch();

  typed_integer_alu DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  typed_integer_alu_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand with bias toward edge values of the selected width
  function automatic logic [63:0] pick_operand(logic [1:0] ws);
    logic [63:0] m;
    m = tialu_pkg::wmask(tialu_pkg::wsel_t'(ws));
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'd1;
      2: return m;
      3: return (m >> 1) + 64'd1;
      4: return m >> 1;
      5: return $urandom_range(0, 70);
      default: return rand64();
    endcase
  endfunction

  // Result side: short random stalls, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_enable && $urandom_range(0, 99) < 2) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(10, 40);
    end else if (stall_enable && $urandom_range(0, 9) < 3) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("typed_integer_alu_tb: FAIL");
      $finish;
    end
  end

  // Present one item and hold it until the transfer
  task automatic send_item(logic [4:0] fn, logic [1:0] ws, logic sgn,
                           logic [63:0] lhs, logic [63:0] rhs);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.width_sel <= ws;
    in_ch.is_signed <= sgn;
    in_ch.lhs       <= lhs;
    in_ch.rhs       <= rhs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [63:0] mn;
    logic [1:0]  ws;
    in_ch.valid     = 1'b0;
    in_ch.func      = '0;
    in_ch.width_sel = '0;
    in_ch.is_signed = 1'b0;
    in_ch.lhs       = '0;
    in_ch.rhs       = '0;
    stall_enable    = 1'b0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_item(tialu_pkg::FN_ADD, tialu_pkg::W64, 1'b0, '1, '1);
    send_item(tialu_pkg::FN_MUL, tialu_pkg::W64, 1'b1, '1, 64'h8000_0000_0000_0000);
    send_item(tialu_pkg::FN_DIV, tialu_pkg::W32, 1'b1, 64'd7, 64'd0);
    send_item(tialu_pkg::FN_MOD, tialu_pkg::W8, 1'b0, 64'hFF, 64'h100);
    send_item(tialu_pkg::FN_DIV, tialu_pkg::W8, 1'b1, 64'h80, 64'hFF);
    send_item(tialu_pkg::FN_MOD, tialu_pkg::W16, 1'b1, 64'h8000, 64'hFFFF);
    send_item(tialu_pkg::FN_DIV, tialu_pkg::W64, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_item(tialu_pkg::FN_MOD, tialu_pkg::W32, 1'b1, 64'hFFFF_FFF9, 64'd2);
    send_item(tialu_pkg::FN_DIV, tialu_pkg::W16, 1'b1, 64'd7, 64'hFFFE);
    send_item(tialu_pkg::FN_SUB, tialu_pkg::W8, 1'b1, 64'h00, 64'h01);
    send_item(tialu_pkg::FN_AND, tialu_pkg::W64, 1'b0, rand64(), rand64());
    send_item(tialu_pkg::FN_OR, tialu_pkg::W16, 1'b0, rand64(), rand64());
    send_item(tialu_pkg::FN_XOR, tialu_pkg::W32, 1'b1, rand64(), rand64());
    send_item(tialu_pkg::FN_SHL, tialu_pkg::W8, 1'b0, 64'hFF, 64'd8);
    send_item(tialu_pkg::FN_SHL, tialu_pkg::W64, 1'b0, 64'd1, 64'd63);
    send_item(tialu_pkg::FN_SHR, tialu_pkg::W16, 1'b1, 64'h8000, 64'd15);
    send_item(tialu_pkg::FN_SHR, tialu_pkg::W32, 1'b1, 64'h8000_0000, 64'hFFFF_FFFF);
    send_item(tialu_pkg::FN_SHR, tialu_pkg::W64, 1'b0, '1, 64'd64);
    send_item(tialu_pkg::FN_LAND, tialu_pkg::W8, 1'b0, 64'h100, 64'd1);
    send_item(tialu_pkg::FN_LOR, tialu_pkg::W32, 1'b0, 64'h1_0000_0000, 64'd0);
    send_item(tialu_pkg::FN_GE, tialu_pkg::W8, 1'b1, 64'h80, 64'h7F);
    send_item(tialu_pkg::FN_GT, tialu_pkg::W8, 1'b0, 64'h80, 64'h7F);
    send_item(tialu_pkg::FN_LE, tialu_pkg::W64, 1'b1, '1, 64'd0);
    send_item(tialu_pkg::FN_LT, tialu_pkg::W16, 1'b1, 64'h8000, 64'h7FFF);
    send_item(tialu_pkg::FN_EQ, tialu_pkg::W8, 1'b1, 64'h1FF, 64'hFF);
    send_item(tialu_pkg::FN_NE, tialu_pkg::W8, 1'b0, 64'h1FF, 64'hFF);
    send_item(5'd31, tialu_pkg::W64, 1'b1, rand64(), rand64());

    // Random items; output stalls switch on for most of the run
    stall_enable = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 60) stall_enable = 1'b0;
      ws = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) begin
        send_item(5'($urandom_range(18, 31)), ws, 1'($urandom()), rand64(), rand64());
      end else if ($urandom_range(0, 9) == 0) begin
        mn = (tialu_pkg::wmask(tialu_pkg::wsel_t'(ws)) >> 1) + 64'd1;
        send_item($urandom_range(0, 1) ? tialu_pkg::FN_DIV : tialu_pkg::FN_MOD, ws, 1'b1,
                  mn | (rand64() & ~tialu_pkg::wmask(tialu_pkg::wsel_t'(ws))), '1);
      end else begin
        send_item(5'($urandom_range(0, 17)), ws, 1'($urandom()),
                  pick_operand(ws), pick_operand(ws));
      end
    end
    in_ch.valid <= 1'b0;
    stall_enable = 1'b1;

    // Drain
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("typed_integer_alu_tb: PASS");
    end else begin
      $display("typed_integer_alu_tb: FAIL");
    end
    $finish;
  end

endmodule
